[rtl/pfc_pkg.sv]
// Package for the partitioned convolver: payload structs, sequencer states
// and fixed field widths. No dependencies.
package pfc_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int TAP_IDX_BITS   = 10;
  localparam int LEN_BITS       = 11;
  localparam int BLOCK_SIZE     = 64;
  localparam int MAX_PARTITIONS = 16;
  localparam int RESET_LEN      = 64;

  typedef struct packed {
    logic                          mode;
    logic [TAP_IDX_BITS-1:0]       tap_index;
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last_in_block;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          last;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACT,
    ST_PAD,
    ST_MAC,
    ST_OUT
  } state_e;

  localparam logic MODE_TAP    = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

endpackage

[rtl/partitioned_fft_convolver.sv]
// Top level of the partitioned convolver: tap staging, active response,
// sample history and one shared multiply-accumulate unit. Uses pfc_pkg.
//
// Usage: in_data_i carries tap loads (mode 0) and audio samples (mode 1)
// on a valid/ready channel. A tap item marked last copies the staged taps
// into the active response, zeroing taps at or beyond response_length;
// in_ready_o is low while this copy runs.
// Samples gather into blocks of BLOCK_SIZE; a marked or full block is
// zero-padded to BLOCK_SIZE, then each output of the block is computed by
// one multiplier stepping over the first L active taps, L the latched
// response length. Results leave on a
// valid/ready channel from an output register; while the receiver stalls
// the sequencer holds and no input is taken. last marks the final output
// of each block. cfg_we_i writes response_length at any time; it takes
// effect at the next finishing tap load.
// After reset the block sweeps all HIST_DEPTH history entries (2048 at the
// default sizes) and the staged and active memories to zero before
// in_ready_o rises.
module partitioned_fft_convolver #(
  parameter int BLOCK_SIZE     = pfc_pkg::BLOCK_SIZE,
  parameter int MAX_PARTITIONS = pfc_pkg::MAX_PARTITIONS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  pfc_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pfc_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic [pfc_pkg::LEN_BITS-1:0] cfg_wdata_i
);

  localparam int CAPACITY   = MAX_PARTITIONS * BLOCK_SIZE;
  localparam int HIST_DEPTH = 2 ** $clog2(CAPACITY + BLOCK_SIZE);
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int TA_W       = $clog2(CAPACITY);
  localparam int K_W        = $clog2(CAPACITY + 1);
  localparam int F_W        = $clog2(BLOCK_SIZE + 1);
  localparam int SB         = pfc_pkg::SAMPLE_BITS;
  localparam int ACC_W      = 2 * SB + K_W + 1;
  localparam int FRAC       = SB - 1;
  localparam int RST_LAT    = (pfc_pkg::RESET_LEN > CAPACITY) ? CAPACITY
                                                               : pfc_pkg::RESET_LEN;

  logic signed [SB-1:0] hist_mem   [HIST_DEPTH];
  logic signed [SB-1:0] staged_mem [CAPACITY];
  logic signed [SB-1:0] active_mem [CAPACITY];

  pfc_pkg::state_e state_q, state_d;

  logic [pfc_pkg::LEN_BITS-1:0] len_q;
  logic [K_W-1:0]   lat_len_q;
  logic [HA_W:0]    clr_cnt_q;
  logic [K_W-1:0]   act_cnt_q;
  logic [K_W-1:0]   k_q;
  logic [HA_W-1:0]  bp_q;
  logic [F_W-1:0]   fill_q;
  logic [F_W-1:0]   cnt_q;
  logic [F_W-1:0]   i_q;
  logic             v1_q, v2_q;
  logic signed [SB-1:0]    a_rd_q, h_rd_q, s_rd_q;
  logic signed [2*SB-1:0]  prod_q;
  logic signed [ACC_W-1:0] acc_q;
  pfc_pkg::out_t           out_q;

  logic in_acc, out_acc, is_tap, is_smp, blk_end, mac_done, issue;
  logic signed [ACC_W-1:0] rnd;
  logic signed [ACC_W-1:0] shf;
  logic signed [SB-1:0]    sat;
  logic [HA_W-1:0] h_waddr, h_raddr;
  logic            h_we;
  logic signed [SB-1:0] h_wdata;
  logic [K_W-1:0]  clamp_len;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign is_tap  = in_acc && (in_data_i.mode == pfc_pkg::MODE_TAP);
  assign is_smp  = in_acc && (in_data_i.mode == pfc_pkg::MODE_SAMPLE);
  assign blk_end = in_data_i.last_in_block || (fill_q == F_W'(BLOCK_SIZE - 1));
  assign issue   = (state_q == pfc_pkg::ST_MAC) && (k_q < lat_len_q);
  assign mac_done = (state_q == pfc_pkg::ST_MAC) && (k_q == lat_len_q) && !v1_q && !v2_q;
  assign clamp_len = (32'(len_q) > CAPACITY) ? K_W'(CAPACITY) : K_W'(len_q);
  assign h_raddr = bp_q + HA_W'(i_q) - HA_W'(k_q);

  // Round half up, floor shift, saturate.
  assign rnd = acc_q + (ACC_W'(1) <<< (FRAC - 1));
  assign shf = rnd >>> FRAC;
  always_comb begin
    if (shf > ACC_W'((1 <<< FRAC) - 1)) begin
      sat = SB'((1 <<< FRAC) - 1);
    end else if (shf < -(ACC_W'(1) <<< FRAC)) begin
      sat = SB'(-(1 <<< FRAC));
    end else begin
      sat = SB'(shf);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfc_pkg::ST_CLEAR: if (clr_cnt_q == (HA_W + 1)'(HIST_DEPTH - 1)) state_d = pfc_pkg::ST_IDLE;
      pfc_pkg::ST_IDLE: begin
        if (is_tap && in_data_i.last_in_block) state_d = pfc_pkg::ST_ACT;
        else if (is_smp && blk_end) state_d = pfc_pkg::ST_PAD;
      end
      pfc_pkg::ST_ACT: if (act_cnt_q == K_W'(CAPACITY)) state_d = pfc_pkg::ST_IDLE;
      pfc_pkg::ST_PAD: if (fill_q == F_W'(BLOCK_SIZE)) state_d = pfc_pkg::ST_MAC;
      pfc_pkg::ST_MAC: if (mac_done) state_d = pfc_pkg::ST_OUT;
      pfc_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = (i_q + F_W'(1) == cnt_q) ? pfc_pkg::ST_IDLE : pfc_pkg::ST_MAC;
        end
      end
      default: state_d = pfc_pkg::ST_CLEAR;
    endcase
  end

  // Outputs and history write port.
  always_comb begin
    in_ready_o  = (state_q == pfc_pkg::ST_IDLE);
    out_valid_o = (state_q == pfc_pkg::ST_OUT);
    h_we    = 1'b0;
    h_waddr = bp_q + HA_W'(fill_q);
    h_wdata = '0;
    case (state_q)
      pfc_pkg::ST_CLEAR: begin
        h_we    = 1'b1;
        h_waddr = clr_cnt_q[HA_W-1:0];
      end
      pfc_pkg::ST_IDLE: begin
        h_we    = is_smp;
        h_wdata = in_data_i.value;
      end
      pfc_pkg::ST_PAD: h_we = (fill_q < F_W'(BLOCK_SIZE));
      default: h_we = 1'b0;
    endcase
  end

  assign out_data_o = out_q;

  always_ff @(posedge clk_i) begin
    if (h_we) hist_mem[h_waddr] <= h_wdata;
    h_rd_q <= hist_mem[h_raddr];
    a_rd_q <= active_mem[k_q[TA_W-1:0]];
    s_rd_q <= staged_mem[act_cnt_q[TA_W-1:0]];
    if (state_q == pfc_pkg::ST_CLEAR && clr_cnt_q < (HA_W + 1)'(CAPACITY)) begin
      staged_mem[clr_cnt_q[TA_W-1:0]] <= '0;
      active_mem[clr_cnt_q[TA_W-1:0]] <= '0;
    end else if (is_tap && 32'(in_data_i.tap_index) < CAPACITY) begin
      staged_mem[in_data_i.tap_index[TA_W-1:0]] <= in_data_i.value;
    end else if (state_q == pfc_pkg::ST_ACT && act_cnt_q != '0) begin
      active_mem[TA_W'(act_cnt_q - K_W'(1))] <=
        (act_cnt_q - K_W'(1) < lat_len_q) ? s_rd_q : '0;
    end
    prod_q <= a_rd_q * h_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pfc_pkg::ST_CLEAR;
      len_q     <= pfc_pkg::LEN_BITS'(pfc_pkg::RESET_LEN);
      lat_len_q <= K_W'(RST_LAT);
      clr_cnt_q <= '0;
      act_cnt_q <= '0;
      k_q       <= '0;
      bp_q      <= '0;
      fill_q    <= '0;
      cnt_q     <= '0;
      i_q       <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      acc_q     <= '0;
      out_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) len_q <= cfg_wdata_i;
      v1_q <= issue;
      v2_q <= v1_q;
      if (v2_q) acc_q <= acc_q + ACC_W'(prod_q);
      if (issue) k_q <= k_q + K_W'(1);
      case (state_q)
        pfc_pkg::ST_CLEAR: clr_cnt_q <= clr_cnt_q + (HA_W + 1)'(1);
        pfc_pkg::ST_IDLE: begin
          act_cnt_q <= '0;
          if (is_tap && in_data_i.last_in_block) lat_len_q <= clamp_len;
          if (is_smp) begin
            fill_q <= fill_q + F_W'(1);
            if (blk_end) cnt_q <= fill_q + F_W'(1);
          end
        end
        pfc_pkg::ST_ACT: act_cnt_q <= act_cnt_q + K_W'(1);
        pfc_pkg::ST_PAD: begin
          if (fill_q < F_W'(BLOCK_SIZE)) fill_q <= fill_q + F_W'(1);
          i_q   <= '0;
          k_q   <= '0;
          acc_q <= '0;
        end
        pfc_pkg::ST_MAC: begin
          if (mac_done) begin
            out_q.out_sample <= sat;
            out_q.last       <= (i_q + F_W'(1) == cnt_q);
          end
        end
        pfc_pkg::ST_OUT: begin
          if (out_acc) begin
            k_q   <= '0;
            acc_q <= '0;
            if (i_q + F_W'(1) == cnt_q) begin
              bp_q   <= bp_q + HA_W'(BLOCK_SIZE);
              fill_q <= '0;
            end else begin
              i_q <= i_q + F_W'(1);
            end
          end
        end
        default: clr_cnt_q <= '0;
      endcase
    end
  end

endmodule

[rtl/pfc_checker.sv]
// Port-level checker for the partitioned convolver, bound to the top level.
// Uses pfc_pkg for payload types.
module pfc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input pfc_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input pfc_pkg::out_t out_data_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_tap_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.mode == pfc_pkg::MODE_TAP) |=> !out_valid_o)
    else $error("tap transaction produced a result");

  a_last_then_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last |=> in_ready_o)
    else $error("block end did not return to accepting input");

endmodule

bind partitioned_fft_convolver pfc_checker u_pfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[verif/testbench.sv]
// Testbench for partitioned_fft_convolver: drives tap loads and audio blocks
// with random idling and checks every output against its own convolution
// predictor. Depends on rtl/pfc_pkg.sv and rtl/partitioned_fft_convolver.sv.
`timescale 1ns / 100ps

module testbench;

  localparam int CAP       = pfc_pkg::BLOCK_SIZE * pfc_pkg::MAX_PARTITIONS;
  localparam int BS        = pfc_pkg::BLOCK_SIZE;
  localparam int FRAC      = pfc_pkg::SAMPLE_BITS - 1;
  localparam int SETTLE    = CAP + 200;
  localparam int MAX_CYCLE = 3000000;

  // Expected convolver outputs, kept in arrival order.
  class conv_scoreboard;
    pfc_pkg::out_t expected_q[$];
    int           errors;
    int           staged[CAP];
    int           active[CAP];
    int           history[CAP];
    int           window[2*BS];
    int           fill;
    int           partitions;
    int unsigned  length_reg;

    function new();
      foreach (staged[k]) begin
        staged[k] = 0;
        active[k] = 0;
        history[k] = 0;
      end
      foreach (window[k]) window[k] = 0;
      fill = 0;
      length_reg = pfc_pkg::RESET_LEN;
      partitions = (pfc_pkg::RESET_LEN + BS - 1) / BS;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_length(logic [pfc_pkg::LEN_BITS-1:0] len);
      length_reg = len;
    endfunction

    function void activate();
      int unsigned len;
      len = (length_reg > CAP) ? CAP : length_reg;
      for (int k = 0; k < CAP; k++) active[k] = (k < len) ? staged[k] : 0;
      partitions = (len + BS - 1) / BS;
    endfunction

    function longint past_sample(int m, int k);
      int d;
      if (k <= m) return window[BS + m - k];
      d = k - m;
      if (d > CAP) return 0;
      return history[CAP - d];
    endfunction

    function void convolve_block(int count);
      longint        acc;
      longint        q;
      pfc_pkg::out_t res;
      for (int i = count; i < BS; i++) window[BS + i] = 0;
      for (int i = 0; i < count; i++) begin
        acc = 0;
        for (int k = 0; k < partitions * BS; k++)
          if (active[k] != 0) acc += longint'(active[k]) * past_sample(i, k);
        q = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
        if (q > (1 << FRAC) - 1) q = (1 << FRAC) - 1;
        if (q < -(1 << FRAC)) q = -(1 << FRAC);
        res.out_sample = q[pfc_pkg::SAMPLE_BITS-1:0];
        res.last = (i + 1 == count);
        expected_q.push_back(res);
      end
      for (int k = 0; k < CAP - BS; k++) history[k] = history[k + BS];
      for (int k = 0; k < BS; k++) begin
        history[CAP - BS + k] = window[BS + k];
        window[k] = window[BS + k];
        window[BS + k] = 0;
      end
      fill = 0;
    endfunction

    function void note_input(pfc_pkg::in_t it);
      if (it.mode == pfc_pkg::MODE_TAP) begin
        if (it.tap_index < CAP) staged[it.tap_index] = it.value;
        if (it.last_in_block) activate();
        return;
      end
      if (fill >= BS) fill = 0;
      window[BS + fill] = it.value;
      fill++;
      if (it.last_in_block || fill >= BS) convolve_block(fill);
    endfunction

    task check_result(pfc_pkg::out_t got);
      pfc_pkg::out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected output %0d last %0b", got.out_sample, got.last));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_sample !== want.out_sample)
        report($sformatf("out_sample %0d, want %0d", got.out_sample, want.out_sample));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  pfc_pkg::in_t                 in_data_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  pfc_pkg::out_t                out_data_o;
  logic                         cfg_we_i;
  logic [pfc_pkg::LEN_BITS-1:0] cfg_wdata_i;

  conv_scoreboard sb = new();
  int  send_idle;
  int  recv_idle;
  bit  hold_go;
  bit  holding;
  int  cycles;

  partitioned_fft_convolver i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("FAIL partitioned_fft_convolver");
      $finish;
    end
  end

  always @(negedge clk_i)
    out_ready_i <= holding ? 1'b0 : ($urandom_range(0, 99) >= recv_idle);

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin
    holding = 1'b0;
    wait (hold_go);
    holding = 1'b1;
    repeat (3000) @(posedge clk_i);
    holding = 1'b0;
  end

  function automatic logic signed [pfc_pkg::SAMPLE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      default: return pfc_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [pfc_pkg::TAP_IDX_BITS-1:0] pick_index(int unsigned span);
    if ($urandom_range(0, 3) == 0) return pfc_pkg::TAP_IDX_BITS'($urandom);
    return pfc_pkg::TAP_IDX_BITS'($urandom_range(0, span - 1));
  endfunction

  // Offer one transaction; returns right after the accepting edge.
  task automatic send_item(logic mode, logic [pfc_pkg::TAP_IDX_BITS-1:0] idx,
                           logic signed [pfc_pkg::SAMPLE_BITS-1:0] val, logic mark);
    pfc_pkg::in_t it;
    it.mode = mode;
    it.tap_index = idx;
    it.value = val;
    it.last_in_block = mark;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.note_input(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_length(logic [pfc_pkg::LEN_BITS-1:0] len);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_length(len);
  endtask

  task automatic load_taps(int unsigned len, bit finish);
    int unsigned span;
    span = (len == 0) ? 1 : ((len > CAP) ? CAP : len);
    for (int t = 0; t < 2; t++)
      send_item(pfc_pkg::MODE_TAP, pick_index(span), pick_value(), 1'b0);
    send_item(pfc_pkg::MODE_TAP, pfc_pkg::TAP_IDX_BITS'($urandom_range(0, span - 1)),
              pick_value(), finish);
  endtask

  int lengths[9] = '{1, 2047, 0, 17, 1024, 64, 2, 130, 48};

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    hold_go = 1'b0;
    send_idle = 18;
    recv_idle = 70;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset length, loading inside a block, extreme values.
    send_item(pfc_pkg::MODE_SAMPLE, '0, 16'sd1000, 1'b0);
    send_item(pfc_pkg::MODE_TAP, 10'd0, 16'sh7fff, 1'b0);
    send_item(pfc_pkg::MODE_TAP, 10'd1023, 16'sh8000, 1'b0);
    send_item(pfc_pkg::MODE_TAP, 10'd1, 16'sh8000, 1'b1);
    send_item(pfc_pkg::MODE_SAMPLE, 10'h3ff, 16'sh7fff, 1'b0);
    send_item(pfc_pkg::MODE_SAMPLE, '0, 16'sh8000, 1'b1);
    send_item(pfc_pkg::MODE_SAMPLE, '0, 16'sh8000, 1'b0);
    send_item(pfc_pkg::MODE_SAMPLE, '0, 16'sh8000, 1'b1);
    send_item(pfc_pkg::MODE_SAMPLE, '0, 16'sh0000, 1'b1);
    send_item(pfc_pkg::MODE_SAMPLE, '0, 16'sh7fff, 1'b1);

    for (int p = 0; p < 9; p++) begin
      drain();
      send_idle = (p < 3) ? 18 : ((p < 6) ? 70 : 0);
      recv_idle = (p < 3) ? 70 : ((p < 6) ? 18 : 0);
      write_length(pfc_pkg::LEN_BITS'(lengths[p]));
      // Skip the finishing mark once: the old response stays active.
      load_taps(lengths[p], p != 5);
      if (p == 0) begin
        hold_go = 1'b1;
        // A full block with no mark plus three more samples, sent into a stalled receiver.
        for (int s = 0; s < BS + 3; s++)
          send_item(pfc_pkg::MODE_SAMPLE, pfc_pkg::TAP_IDX_BITS'($urandom),
                    pick_value(), 1'b0);
      end else begin
        for (int s = 0; s < 3; s++)
          send_item(pfc_pkg::MODE_SAMPLE, pfc_pkg::TAP_IDX_BITS'($urandom),
                    pick_value(), $urandom_range(0, 3) == 0);
      end
    end
    send_item(pfc_pkg::MODE_SAMPLE, pfc_pkg::TAP_IDX_BITS'($urandom), pick_value(), 1'b1);

    drain();
    while (sb.expected_q.size() != 0) begin
      void'(sb.expected_q.pop_front());
      sb.report("expected output never arrived");
    end
    if (sb.errors == 0) begin
      $display("PASS partitioned_fft_convolver");
    end else begin
      $display("FAIL partitioned_fft_convolver");
    end
    $finish;
  end

endmodule

[partitioned_fft_convolver.f]
rtl/pfc_pkg.sv
rtl/partitioned_fft_convolver.sv
rtl/pfc_checker.sv
verif/testbench.sv
